@@ src/rirs_pkg.sv @@
`timescale 1ns / 1ps
// rirs_pkg: status, verdict and compare codes plus the byte-cover helper
// for the rejection sampler. No dependencies.
package rirs_pkg;

  // limit_status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BELOW_MIN  = 2'd1;
  localparam logic [1:0] ST_EVEN       = 2'd2;
  localparam logic [1:0] ST_NOT_LOADED = 2'd3;

  // verdict codes
  localparam logic [1:0] VD_PENDING  = 2'd0;
  localparam logic [1:0] VD_ACCEPT   = 2'd1;
  localparam logic [1:0] VD_ZERO     = 2'd2;
  localparam logic [1:0] VD_TOO_BIG  = 2'd3;

  // running big-endian compare
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] MIN_LIMIT = 8'd3;

  // smallest 2^k-1 that is >= b (bit smear)
  function automatic logic [7:0] cover_mask(input logic [7:0] b);
    logic [7:0] m;
    m = b | (b >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    return m;
  endfunction

endpackage

@@ src/random_in_range_rejection_sampler.sv @@
`timescale 1ns / 1ps
// random_in_range_rejection_sampler: top level, limit load and candidate test.
// Depends on rirs_pkg and rirs_lmem.

// Loads a limit n as big-endian bytes (tuser = 0), dropping leading zero
// bytes and keeping up to MAX_BYTES significant bytes in a one-port-read
// memory, then tests random candidates (tuser = 1) of exactly that many
// bytes. Every input word yields one output word: for limit words the load
// status and byte count, for candidate words the masked byte, with the
// verdict and tlast on the candidate's final byte. The limit is rejected if
// below 3 or even; candidates are ignored (zero output) until a good limit
// is loaded. Throughput is one word per clock: the store is read ahead
// at the next candidate position, so the limit byte for the compare
// is already in the read register when the random byte arrives. A single
// output register takes the next result in the same cycle the previous one
// is taken, so the input stalls only while a result waits on the output.
// The output is registered, valid in the cycle after input acceptance.
// The store needs no clearing after reset: only entries of the current
// load are ever read.
module random_in_range_rejection_sampler #(
  parameter int MAX_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] req_type: 0 limit, 1 candidate
  input  logic        s_axis_tlast,  // limit_last
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [9:8] limit_status,
                                     // [11:10] verdict, [19:12] sig_len_out
  output logic        m_axis_tlast   // result_last
);

  localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);

  // load state
  logic [CNT_W-1:0]  sig_count, sig_count_next;
  logic [7:0]        top_mask, top_mask_next;
  logic              seen_nonzero, seen_nonzero_next;
  logic [1:0]        load_status, load_status_next;
  logic [7:0]        first_byte, first_byte_next;  // entry 0
  logic [7:0]        last_byte, last_byte_next;    // highest written entry
  // candidate state
  logic [ADDR_W-1:0] cand_pos, cand_pos_next;
  logic [1:0]        cmp_state, cmp_state_next;
  logic              any_nonzero, any_nonzero_next;

  // output register
  logic [7:0]        out_byte, out_byte_next;
  logic [1:0]        out_status, out_status_next;
  logic [1:0]        out_verdict, out_verdict_next;
  logic              out_last, out_last_next;
  logic [CNT_W-1:0]  out_len, out_len_next;

  logic              accept;
  logic [7:0]        din;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        lim;

  // load scratch
  logic [CNT_W-1:0]  sc0, sc1;
  logic              seen0, seen1, store;
  logic [7:0]        first1, last1;
  // candidate scratch
  logic [7:0]        cb;
  logic              cand_end;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign din           = s_axis_tdata;

  assign m_axis_tdata = {4'b0, 8'(out_len), out_verdict, out_status, out_byte};
  assign m_axis_tlast = out_last;

  rirs_lmem #(
    .DEPTH  (MAX_BYTES),
    .ADDR_W (ADDR_W)
  ) u_lmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (din),
    .rd_addr (cand_pos_next),  // prefetch for the next candidate word
    .rd_data (lim)
  );

  always_comb begin
    sig_count_next    = sig_count;
    top_mask_next     = top_mask;
    seen_nonzero_next = seen_nonzero;
    load_status_next  = load_status;
    first_byte_next   = first_byte;
    last_byte_next    = last_byte;
    cand_pos_next     = cand_pos;
    cmp_state_next    = cmp_state;
    any_nonzero_next  = any_nonzero;

    out_byte_next    = 8'd0;
    out_status_next  = load_status;
    out_verdict_next = rirs_pkg::VD_PENDING;
    out_last_next    = 1'b0;
    out_len_next     = sig_count;

    mem_we    = 1'b0;
    mem_waddr = sig_count[ADDR_W-1:0];

    // a limit word after a finished load restarts the load
    sc0    = (load_status != rirs_pkg::ST_NOT_LOADED) ? '0 : sig_count;
    seen0  = (load_status != rirs_pkg::ST_NOT_LOADED) ? 1'b0 : seen_nonzero;
    seen1  = seen0 || (din != 8'd0);
    store  = seen1 && (sc0 < CNT_MAX);
    sc1    = sc0 + CNT_W'(store);
    first1 = (store && (sc0 == '0)) ? din : first_byte;
    last1  = store ? din : last_byte;

    cb       = (cand_pos == '0) ? (din & top_mask) : din;
    cand_end = ((CNT_W'(cand_pos) + CNT_W'(1)) == sig_count);

    if (accept) begin
      if (!s_axis_tuser) begin
        // limit byte
        mem_we            = store;
        mem_waddr         = sc0[ADDR_W-1:0];
        sig_count_next    = sc1;
        seen_nonzero_next = seen1;
        first_byte_next   = first1;
        last_byte_next    = last1;
        if (load_status != rirs_pkg::ST_NOT_LOADED) begin
          top_mask_next = rirs_pkg::BYTE_ONES;
        end
        if (!seen0 && (din != 8'd0)) begin
          top_mask_next = rirs_pkg::cover_mask(din);
        end
        if (s_axis_tlast) begin
          if ((sc1 == '0) || ((sc1 == CNT_W'(1)) && (first1 < rirs_pkg::MIN_LIMIT))) begin
            load_status_next = rirs_pkg::ST_BELOW_MIN;
          end else if (!last1[0]) begin
            load_status_next = rirs_pkg::ST_EVEN;
          end else begin
            load_status_next = rirs_pkg::ST_OK;
          end
        end else begin
          load_status_next = rirs_pkg::ST_NOT_LOADED;
        end
        cand_pos_next    = '0;
        cmp_state_next   = rirs_pkg::CMP_EQ;
        any_nonzero_next = 1'b0;
        out_status_next  = load_status_next;
        out_len_next     = sc1;
      end else if ((load_status == rirs_pkg::ST_OK) && (sig_count != '0)) begin
        // candidate byte against prefetched limit byte
        if (cmp_state == rirs_pkg::CMP_EQ) begin
          if (cb < lim) begin
            cmp_state_next = rirs_pkg::CMP_LT;
          end else if (cb > lim) begin
            cmp_state_next = rirs_pkg::CMP_GT;
          end
        end
        any_nonzero_next = any_nonzero || (cb != 8'd0);
        out_byte_next    = cb;
        if (cand_end) begin
          if (!any_nonzero_next) begin
            out_verdict_next = rirs_pkg::VD_ZERO;
          end else if (cmp_state_next != rirs_pkg::CMP_LT) begin
            out_verdict_next = rirs_pkg::VD_TOO_BIG;
          end else begin
            out_verdict_next = rirs_pkg::VD_ACCEPT;
          end
          out_last_next    = 1'b1;
          cand_pos_next    = '0;
          cmp_state_next   = rirs_pkg::CMP_EQ;
          any_nonzero_next = 1'b0;
        end else begin
          cand_pos_next = cand_pos + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_count     <= '0;
      top_mask      <= rirs_pkg::BYTE_ONES;
      seen_nonzero  <= 1'b0;
      load_status   <= rirs_pkg::ST_NOT_LOADED;
      cand_pos      <= '0;
      cmp_state     <= rirs_pkg::CMP_EQ;
      any_nonzero   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      sig_count     <= sig_count_next;
      top_mask      <= top_mask_next;
      seen_nonzero  <= seen_nonzero_next;
      load_status   <= load_status_next;
      cand_pos      <= cand_pos_next;
      cmp_state     <= cmp_state_next;
      any_nonzero   <= any_nonzero_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_byte <= first_byte_next;
    last_byte  <= last_byte_next;
    if (accept) begin
      out_byte    <= out_byte_next;
      out_status  <= out_status_next;
      out_verdict <= out_verdict_next;
      out_last    <= out_last_next;
      out_len     <= out_len_next;
    end
  end

endmodule

@@ src/rirs_lmem.sv @@
`timescale 1ns / 1ps
// rirs_lmem: limit byte store, one write and one registered read port.
// Write-first forwarding when both ports hit one entry. No package use.
module rirs_lmem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-entry overlap: hand the new byte straight to the read register
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
